// File: src/prq_pkg.sv
package prq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam logic [5:0]  QuantumCap        = 6'd32;

  typedef enum logic [2:0] {
    CmdPush   = 3'd0,
    CmdPop    = 3'd1,
    CmdRotate = 3'd2,
    CmdDouble = 3'd3,
    CmdSetTtl = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef enum logic {
    StIdle  = 1'b0,
    StFetch = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [15:0] id;
    logic [2:0]  state;
    logic [3:0]  prio;
    logic [5:0]  quantum;
    logic [15:0] ttl;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] entry_id;
    logic [2:0]  entry_state;
    logic [3:0]  entry_priority;
    logic [5:0]  entry_quantum;
    logic [15:0] ttl_value;
  } in_t;

  typedef struct packed {
    logic        out_valid;
    logic [15:0] out_id;
    logic [2:0]  out_state;
    logic [3:0]  out_priority;
    logic [5:0]  out_quantum;
    logic [15:0] out_ttl;
    logic        is_empty;
    logic [4:0]  entry_count;
    logic [1:0]  status;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic fetch;
    logic load;
  } prq_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic needs_fetch;
    logic result_now;
    logic fetch_result;
  } prq_stat_t;

endpackage

// File: src/prq_ram.sv
module prq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/prq_ctrl.sv
module prq_ctrl
  import prq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  prq_stat_t stat_i,
  output prq_ctrl_t ctrl_o
);

  ctrl_state_e state_q, state_d;
  logic        out_full_q, out_full_d;
  logic        slot_free;

  // the result slot is free if empty or drained at this edge
  assign slot_free = !out_full_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (ctrl_o.accept && stat_i.needs_fetch) begin
          state_d = StFetch;
        end
      end
      StFetch: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    ctrl_o.fetch  = 1'b0;
    case (state_q)
      StIdle: begin
        in_stall_o = !slot_free;
      end
      StFetch: begin
        ctrl_o.fetch = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    ctrl_o.accept = in_valid_i && !in_stall_o;
    ctrl_o.load   = (ctrl_o.accept && stat_i.result_now) ||
                    (ctrl_o.fetch && stat_i.fetch_result);
  end

  always_comb begin
    out_full_d = out_full_q;
    if (ctrl_o.load) begin
      out_full_d = 1'b1;
    end else if (!out_stall_i) begin
      out_full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      out_full_q <= out_full_d;
    end
  end

  assign out_valid_o = out_full_q;

endmodule

// File: src/prq_datapath.sv
module prq_datapath
  import prq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_t       in_data_i,
  input  prq_ctrl_t ctrl_i,
  output prq_stat_t stat_o,
  output out_t      out_data_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ExtW = CntW + 5;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  logic [PtrW-1:0] head_ptr_q, head_ptr_d, tail_ptr_q, tail_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            rot_q;
  entry_t          head_q, head_d;
  out_t            out_q, res, fetch_res;

  logic            we, re, needs_fetch;
  entry_t          wdata, rdata, pushed, rep;
  logic            rep_valid;
  status_e         status;
  logic [ExtW-1:0] cnt_ext, cnt_q_ext;

  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  assign pushed = '{id: in_data_i.entry_id, state: in_data_i.entry_state,
                    prio: in_data_i.entry_priority,
                    quantum: in_data_i.entry_quantum, ttl: in_data_i.ttl_value};

  always_comb begin
    head_ptr_d  = head_ptr_q;
    tail_ptr_d  = tail_ptr_q;
    count_d     = count_q;
    head_d      = head_q;
    we          = 1'b0;
    wdata       = pushed;
    needs_fetch = 1'b0;
    status      = StatusOk;
    rep         = head_q;
    rep_valid   = (count_q != '0);
    if (in_data_i.cmd == CmdPush) begin
      if (count_q == FullCnt) begin
        status = StatusFull;
      end else begin
        we         = 1'b1;
        tail_ptr_d = advance(tail_ptr_q);
        count_d    = count_q + 1'b1;
        if (count_q == '0) begin
          head_d    = pushed;
          rep       = pushed;
          rep_valid = 1'b1;
        end
      end
    end else if (count_q == '0 && in_data_i.cmd <= CmdSetTtl) begin
      status = StatusEmpty;
    end else begin
      case (in_data_i.cmd)
        CmdPop: begin
          head_ptr_d  = advance(head_ptr_q);
          count_d     = count_q - 1'b1;
          needs_fetch = (count_q > CntW'(1));
        end
        CmdRotate: begin
          // a lone entry stays where it is
          if (count_q > CntW'(1)) begin
            we          = 1'b1;
            wdata       = head_q;
            head_ptr_d  = advance(head_ptr_q);
            tail_ptr_d  = advance(tail_ptr_q);
            needs_fetch = 1'b1;
          end
        end
        CmdDouble: begin
          head_d.quantum = (head_q.quantum < QuantumCap) ?
                           {head_q.quantum[4:0], 1'b0} : QuantumCap;
          rep            = head_d;
        end
        CmdSetTtl: begin
          head_d.ttl = in_data_i.ttl_value;
          rep        = head_d;
        end
        default: begin
          rep = head_q;
        end
      endcase
    end
  end

  assign re = ctrl_i.accept && needs_fetch;

  assign cnt_ext   = ExtW'(count_d);
  assign cnt_q_ext = ExtW'(count_q);

  always_comb begin
    res              = '0;
    res.is_empty     = (count_d == '0);
    res.entry_count  = cnt_ext[4:0];
    res.status       = status;
    if (rep_valid) begin
      res.out_valid    = 1'b1;
      res.out_id       = rep.id;
      res.out_state    = rep.state;
      res.out_priority = rep.prio;
      res.out_quantum  = rep.quantum;
      res.out_ttl      = rep.ttl;
    end
  end

  // rotate result built from the new head read out of the ram
  always_comb begin
    fetch_res              = '0;
    fetch_res.out_valid    = 1'b1;
    fetch_res.out_id       = rdata.id;
    fetch_res.out_state    = rdata.state;
    fetch_res.out_priority = rdata.prio;
    fetch_res.out_quantum  = rdata.quantum;
    fetch_res.out_ttl      = rdata.ttl;
    fetch_res.entry_count  = cnt_q_ext[4:0];
    fetch_res.status       = StatusOk;
  end

  prq_ram #(
    .Width(EntryW),
    .Depth(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.accept && we),
    .waddr_i(tail_ptr_q),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(head_ptr_d),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ptr_q <= '0;
      tail_ptr_q <= '0;
      count_q    <= '0;
      rot_q      <= 1'b0;
    end else if (ctrl_i.accept) begin
      head_ptr_q <= head_ptr_d;
      tail_ptr_q <= tail_ptr_d;
      count_q    <= count_d;
      rot_q      <= (in_data_i.cmd == CmdRotate);
    end
  end

  // head copy lives in flops; the ram slot under the head pointer goes stale
  always_ff @(posedge clk_i) begin
    if (ctrl_i.fetch) begin
      head_q <= rdata;
    end else if (ctrl_i.accept) begin
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fetch && ctrl_i.load) begin
      out_q <= fetch_res;
    end else if (ctrl_i.load) begin
      out_q <= res;
    end
  end

  assign stat_o.needs_fetch  = needs_fetch;
  assign stat_o.result_now   = !(needs_fetch && in_data_i.cmd == CmdRotate);
  assign stat_o.fetch_result = rot_q;
  assign out_data_o          = out_q;

endmodule

// File: src/process_ready_queue_unit.sv
// fifo ready queue of process descriptors with round-robin rotate
// input channel: one command beat (push, pop, rotate, double quantum, set ttl)
// output channel: one result beat per command, with the popped entry for pop
//   or the head after the command otherwise, plus empty flag, count and status
// both channels use valid/stall; a beat moves when valid is high and stall low
// the result is registered; pop and rotate on a queue of two or more entries
//   read the next head from the entry ram, and a rotate result is registered
//   from that ram read rather than when the command is accepted
// throughput: one command per cycle while no stalled result blocks input; pop
//   and rotate with two or more entries hold off the next command for the ram read of the new head
// a command is taken while the previous result waits, as long as that result
//   is drained in the same cycle; a stalled result holds and blocks new input
// reset empties the queue (pointers and count cleared) and drops any pending
//   result; the entry ram itself is not cleared
module process_ready_queue_unit
  import prq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  prq_ctrl_t ctrl;
  prq_stat_t stat;

  prq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  prq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .out_data_o(out_data_o)
  );

endmodule

// File: src/prq_checker.sv
module prq_checker
  import prq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // a held result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // an empty-queue status reports no entry and an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StatusEmpty |->
      out_data_o.is_empty && !out_data_o.out_valid && out_data_o.entry_count == 5'd0)
    else $error("empty status with entry or nonzero count");

  // a dropped push means a full queue, so a head is reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StatusFull |->
      !out_data_o.is_empty && out_data_o.out_valid)
    else $error("full status without a head entry");

  // input cannot be taken while a result is stuck in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result stalled");

endmodule

bind process_ready_queue_unit prq_checker u_prq_checker (.*);

// File: tb/tb_top.sv
module tb_top
  import prq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // command codes the block must treat as no-ops
  localparam logic [2:0] CmdSpareA = 3'd5;
  localparam logic [2:0] CmdSpareB = 3'd6;
  localparam logic [2:0] CmdSpareC = 3'd7;

  localparam int ItemTarget = 530;
  localparam int IdleLimit  = 1000;

  logic clk_i     = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  // mirror of the queue, updated as each command beat is taken
  entry_t q_slots [QueueDepthDefault];
  int     q_head = 0;
  int     q_tail = 0;
  int     q_fill = 0;

  out_t   pending_results [$];
  int     errors      = 0;
  int     sent_items  = 0;
  int     result_beats = 0;
  int     idle_cycles = 0;
  int     stall_left  = 0;
  bit     calm_in     = 1'b0;
  bit     calm_out    = 1'b0;

  process_ready_queue_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int step_ptr(input int i);
    return (i + 1 >= QueueDepthDefault) ? 0 : i + 1;
  endfunction

  function automatic out_t predict_queue(input in_t item);
    entry_t     shown;
    logic [1:0] st;
    logic       have_entry;
    shown      = '0;
    st         = StatusOk;
    have_entry = 1'b0;
    case (item.cmd)
      CmdPush: begin
        if (q_fill >= QueueDepthDefault) begin
          st = StatusFull;
        end else begin
          q_slots[q_tail] = entry_t'({item.entry_id, item.entry_state, item.entry_priority,
                                      item.entry_quantum, item.ttl_value});
          q_tail = step_ptr(q_tail);
          q_fill++;
        end
      end
      CmdPop, CmdRotate, CmdDouble, CmdSetTtl: begin
        if (q_fill == 0) begin
          st = StatusEmpty;
        end else if (item.cmd == CmdPop) begin
          shown      = q_slots[q_head];
          have_entry = 1'b1;
          q_head     = step_ptr(q_head);
          q_fill--;
        end else if (item.cmd == CmdRotate) begin
          // a lone entry stays where it is
          if (q_fill > 1) begin
            q_slots[q_tail] = q_slots[q_head];
            q_head = step_ptr(q_head);
            q_tail = step_ptr(q_tail);
          end
        end else if (item.cmd == CmdDouble) begin
          if (q_slots[q_head].quantum < QuantumCap) begin
            q_slots[q_head].quantum = q_slots[q_head].quantum << 1;
          end else begin
            q_slots[q_head].quantum = QuantumCap;
          end
        end else begin
          q_slots[q_head].ttl = item.ttl_value;
        end
      end
      default: ;
    endcase
    if (item.cmd != CmdPop && q_fill != 0) begin
      shown      = q_slots[q_head];
      have_entry = 1'b1;
    end
    return out_t'({have_entry, shown, (q_fill == 0), 5'(q_fill), st});
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < 60) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string fname, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                result_beats, fname, got, want));
    end
  endtask

  task automatic compare_result(input out_t got, input out_t want);
    check_field("out_valid", 32'(got.out_valid), 32'(want.out_valid));
    check_field("out_id", 32'(got.out_id), 32'(want.out_id));
    check_field("out_state", 32'(got.out_state), 32'(want.out_state));
    check_field("out_priority", 32'(got.out_priority), 32'(want.out_priority));
    check_field("out_quantum", 32'(got.out_quantum), 32'(want.out_quantum));
    check_field("out_ttl", 32'(got.out_ttl), 32'(want.out_ttl));
    check_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
    check_field("entry_count", 32'(got.entry_count), 32'(want.entry_count));
    check_field("status", 32'(got.status), 32'(want.status));
  endtask

  // sampled mid-cycle so the values seen are the ones that hold at the next rising edge
  always @(negedge clk_i) begin
    out_t want;
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending: %h", out_data_o));
        end else begin
          want = pending_results.pop_front();
          compare_result(out_data_o, want);
        end
        result_beats++;
      end
      if (in_valid && !in_stall_o) pending_results.push_back(predict_queue(in_data));
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("[%0t] timeout with %0d results pending", $time, pending_results.size());
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // receiver back-pressure: mostly short bursts, now and then a long one
  always @(posedge clk_i) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (calm_out || r < 60) begin
      out_stall <= 1'b0;
    end else if (r < 95) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(10, 40);
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_in || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called right after a rising edge; returns right after the edge that takes the beat
  task automatic send_cmd(input in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    sent_items++;
  endtask

  task automatic send_push(input logic [15:0] id, input logic [2:0] st,
                           input logic [3:0] pr, input logic [5:0] qt,
                           input logic [15:0] ttl);
    send_cmd(in_t'({CmdPush, id, st, pr, qt, ttl}));
  endtask

  // non-push command; the unused entry fields carry noise
  task automatic send_op(input logic [2:0] c, input logic [15:0] ttl);
    send_cmd(in_t'({c, 16'($urandom), 3'($urandom), 4'($urandom), 6'($urandom), ttl}));
  endtask

  task automatic send_random_push();
    send_push(16'($urandom), 3'($urandom), 4'($urandom), 6'($urandom), 16'($urandom));
  endtask

  task automatic send_random_op(input int push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      send_random_push();
    end else begin
      r = $urandom_range(0, 99);
      if (r < 30)      send_op(CmdPop, 16'($urandom));
      else if (r < 55) send_op(CmdRotate, 16'($urandom));
      else if (r < 75) send_op(CmdDouble, 16'($urandom));
      else if (r < 94) send_op(CmdSetTtl, 16'($urandom));
      else             send_op(3'($urandom_range(CmdSpareA, CmdSpareC)), 16'($urandom));
    end
  endtask

  // drop valid so the last beat is not taken again, then drain
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_queue();
    send_op(CmdPop, 16'hFFFF);
    send_op(CmdRotate, 16'h0000);
    send_op(CmdDouble, 16'hFFFF);
    send_op(CmdSetTtl, 16'hFFFF);
    send_op(CmdSpareA, 16'h0000);
  endtask

  task automatic test_single_entry();
    send_push(16'hFFFF, 3'h7, 4'hF, 6'h3F, 16'hFFFF);
    send_op(CmdRotate, 16'h1234);
    send_op(CmdDouble, 16'h0000);   // above the cap, clamps
    send_op(CmdDouble, 16'h0000);   // exactly at the cap
    send_op(CmdSetTtl, 16'h0000);
    send_op(CmdPop, 16'h0000);
  endtask

  task automatic test_quantum_doubling();
    send_push(16'h0001, 3'h1, 4'h2, 6'd0, 16'h0100);
    send_op(CmdDouble, 16'h0000);   // zero stays zero
    send_push(16'h8000, 3'h4, 4'h8, 6'd31, 16'h8000);
    send_op(CmdRotate, 16'h0000);
    send_op(CmdDouble, 16'h0000);
    send_op(CmdDouble, 16'h0000);
    send_op(CmdPop, 16'h0000);
    send_op(CmdPop, 16'h0000);
    send_op(CmdPop, 16'h0000);
  endtask

  task automatic test_spare_codes();
    send_push(16'h0000, 3'h0, 4'h0, 6'h00, 16'h0000);
    send_op(CmdSpareB, 16'hFFFF);
    send_op(CmdSpareC, 16'hFFFF);
    send_op(CmdPop, 16'hFFFF);
    wait_for_results();
  endtask

  task automatic fill_to_full();
    while (q_fill < QueueDepthDefault) send_random_push();
    repeat ($urandom_range(1, 3)) send_random_push();
    repeat ($urandom_range(0, 4)) send_random_op(30);
  endtask

  task automatic drain_to_empty();
    while (q_fill > 0) begin
      if ($urandom_range(0, 3) == 0) send_random_op(0);
      else send_op(CmdPop, 16'($urandom));
    end
    repeat ($urandom_range(1, 2)) send_random_op(0);
  endtask

  task automatic random_mix();
    repeat ($urandom_range(10, 40)) send_random_op(45);
  endtask

  task automatic test_random_traffic();
    int kind;
    while (sent_items < ItemTarget) begin
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 3);
      case (kind)
        0: fill_to_full();
        1: drain_to_empty();
        default: random_mix();
      endcase
      if ($urandom_range(0, 5) == 0) wait_for_results();
    end
    calm_in  = 1'b0;
    calm_out = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_single_entry();
    test_quantum_doubling();
    test_spare_codes();
    test_random_traffic();
    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
